// ----- hw/rtl/alur_pkg.sv -----
// package for the arc length uniform resampler
// shared types, constants and the controller/datapath command struct
`timescale 1ns / 1ps

package alur_pkg;

    typedef struct packed {
        logic        cycle_start;
        logic        edge_start;
        logic        reversed;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] arc_pos;
        logic [31:0] edge_len;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic        last_of_run;
        logic        overflowed;
    } t_out_item;

    localparam int unsigned DivBits = 64;

    // datapath operation codes
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ADVANCE,
        OP_SKIP_START,
        OP_SKIP_STEP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_y;
    } t_cmd;

    typedef struct packed {
        logic reach;
        logic interp;
        logic div_done;
        logic skip_done;
        logic empty_or_edge;
    } t_status;

endpackage

// ----- hw/rtl/alur_datapath.sv -----
// datapath: target tracking, bit-serial rounding divider and skip divider
// depends on alur_pkg
`timescale 1ns / 1ps

module alur_datapath
    import alur_pkg::*;
#(
    parameter int MAX_POINTS_PER_ITEM = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  t_in_item    i_item,
    input  logic [31:0] i_step_length,
    input  logic        i_rst_n,
    output t_status     o_status,
    output logic [31:0] o_x,
    output logic [31:0] o_y,
    output logic        o_ovf
);
    localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int CNT_W = $clog2(DivBits + 1);

    logic [32:0] r_target;
    logic signed [32:0] r_prev_x, r_prev_y;
    logic [31:0] r_prev_dist, r_pend;
    logic signed [32:0] r_cur_x, r_cur_y;
    logic [31:0] r_dist;
    logic [32:0] r_step;

    // divider state (restoring, one bit per cycle)
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [63:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic        r_neg;
    logic [31:0] r_res_x;

    logic signed [32:0] px, py;
    logic [31:0] dist_in, step_eff;
    logic [32:0] tgt_after_cs, tgt_after_es;
    logic [39:0] cap_reach;
    logic es;

    assign step_eff = (i_step_length == 32'd0) ? 32'd1 : i_step_length;
    assign es = i_item.edge_start | i_item.cycle_start;
    assign px = 33'(signed'(i_item.pos_x[CW-1:0]));
    assign py = 33'(signed'(i_item.pos_y[CW-1:0]));
    assign dist_in = i_item.reversed
        ? ((i_item.arc_pos > i_item.edge_len) ? 32'd0 : i_item.edge_len - i_item.arc_pos)
        : i_item.arc_pos;

    // the item hits the cap when a target is still reached after the last allowed point
    assign cap_reach = 40'(r_target) + 40'(step_eff) * 40'(MAX_POINTS_PER_ITEM);

    // target update at item load
    always_comb begin
        logic [31:0] pend;
        pend = i_item.cycle_start ? 32'd0 : r_pend;
        tgt_after_cs = i_item.cycle_start ? {2'b0, step_eff[31:1]} : r_target;
        tgt_after_es = (tgt_after_cs >= {1'b0, pend}) ? tgt_after_cs - {1'b0, pend} : 33'd0;
    end

    // magnitude and numerator for interpolation
    logic signed [33:0] diff;
    logic [32:0] mag;
    logic [31:0] frac_num;
    logic [64:0] prod;
    assign diff = i_cmd.div_y ? (34'(r_cur_y) - 34'(r_prev_y)) : (34'(r_cur_x) - 34'(r_prev_x));
    assign mag = diff[33] ? 33'(-diff) : 33'(diff);
    assign frac_num = 32'(r_target - {1'b0, r_prev_dist});
    assign prod = 65'(mag) * 65'(frac_num);

    // divider bit step
    logic [32:0] rem_sh;
    assign rem_sh = {r_rem, r_num[63]};
    logic [32:0] dcmp;
    assign dcmp = (i_cmd.op == OP_SKIP_STEP) ? r_step : {1'b0, r_den};

    logic [32:0] lerp_q;
    logic signed [32:0] lerp_v, base;
    assign base = i_cmd.div_y ? r_prev_y : r_prev_x;
    assign lerp_q = 33'(r_quo);
    assign lerp_v = r_neg ? base - signed'(lerp_q) : base + signed'(lerp_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 33'd32768;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_dist <= '0;
            r_pend <= '0;
            r_cnt <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_cur_x <= px;
                    r_cur_y <= py;
                    r_dist <= dist_in;
                    r_step <= {1'b0, step_eff};
                    o_ovf <= (cap_reach <= 40'(dist_in));
                    if (es) begin
                        r_target <= tgt_after_es;
                        r_pend <= i_item.edge_len;
                        if (i_item.edge_len != 32'd0) begin
                            r_prev_x <= px;
                            r_prev_y <= py;
                            r_prev_dist <= dist_in;
                        end
                    end
                end
                OP_DIV_START: begin
                    r_num <= 64'(prod) + 64'({1'b0, r_dist - r_prev_dist} >> 1);
                    r_rem <= '0;
                    r_den <= r_dist - r_prev_dist;
                    r_quo <= '0;
                    r_neg <= diff[33];
                    r_cnt <= CNT_W'(DivBits);
                end
                OP_DIV_STEP: begin
                    if (r_cnt != '0) begin
                        r_num <= {r_num[62:0], 1'b0};
                        if (rem_sh >= dcmp) begin
                            r_rem <= 32'(rem_sh - dcmp);
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= 32'(rem_sh);
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end else if (!i_cmd.div_y) begin
                        r_res_x <= 32'(lerp_v);
                    end else begin
                        o_x <= r_res_x;
                        o_y <= 32'(lerp_v);
                    end
                end
                OP_ADVANCE: begin
                    if (r_dist <= r_prev_dist) begin
                        o_x <= 32'(r_cur_x);
                        o_y <= 32'(r_cur_y);
                    end else if (r_target <= {1'b0, r_prev_dist}) begin
                        o_x <= 32'(r_prev_x);
                        o_y <= 32'(r_prev_y);
                    end
                    r_target <= r_target + r_step;
                end
                OP_SKIP_START: begin
                    r_num <= {32'(r_dist - 32'(r_target)), 32'd0};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= CNT_W'(32);
                end
                OP_SKIP_STEP: begin
                    if (r_cnt != '0) begin
                        r_num <= {r_num[62:0], 1'b0};
                        if (rem_sh >= dcmp) begin
                            r_rem <= 32'(rem_sh - dcmp);
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= 32'(rem_sh);
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_target <= 33'(r_target + 65'(r_quo[31:0] + 33'd1) * 65'(r_step));
                    end
                end
                OP_FINISH: begin
                    r_prev_x <= r_cur_x;
                    r_prev_y <= r_cur_y;
                    r_prev_dist <= r_dist;
                end
                default: ;
            endcase
        end
    end

    assign o_status.reach = r_target <= {1'b0, r_dist};
    assign o_status.interp = (r_dist > r_prev_dist) && (r_target > {1'b0, r_prev_dist});
    assign o_status.div_done = r_cnt == '0;
    assign o_status.skip_done = r_cnt == '0;
    assign o_status.empty_or_edge = es || (i_item.edge_len == 32'd0);
endmodule

// ----- hw/rtl/alur_ctrl.sv -----
// controller state machine sequencing load, divide, emit and skip
// depends on alur_pkg
`timescale 1ns / 1ps

module alur_ctrl
    import alur_pkg::*;
#(
    parameter int MAX_POINTS_PER_ITEM = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_last
);
    localparam int PW = $clog2(MAX_POINTS_PER_ITEM + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIVX0, S_DIVX, S_DIVY0, S_DIVY, S_ADV, S_EMIT, S_SKIP0, S_SKIP,
        S_FIN
    } t_state;

    t_state r_state;
    logic [PW-1:0] r_count;
    logic r_hold;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '{op: OP_NONE, div_y: 1'b0};
        unique case (r_state)
            S_IDLE:  if (i_in_valid) o_cmd.op = OP_LOAD;
            S_DIVX0: o_cmd.op = OP_DIV_START;
            S_DIVX:  o_cmd.op = OP_DIV_STEP;
            S_DIVY0: begin o_cmd.op = OP_DIV_START; o_cmd.div_y = 1'b1; end
            S_DIVY:  begin o_cmd.op = OP_DIV_STEP; o_cmd.div_y = 1'b1; end
            S_ADV:   o_cmd.op = OP_ADVANCE;
            S_SKIP0: o_cmd.op = OP_SKIP_START;
            S_SKIP:  o_cmd.op = OP_SKIP_STEP;
            S_FIN:   o_cmd.op = OP_FINISH;
            default: ;
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_out_valid <= 1'b0;
            o_last <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_count <= '0;
                    r_hold <= 1'b0;
                    r_state <= i_status.empty_or_edge ? S_IDLE : S_CHECK;
                end
                S_CHECK: begin
                    if (!i_status.reach) begin
                        if (r_hold) begin
                            o_last <= 1'b1;
                            o_out_valid <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (r_count == PW'(MAX_POINTS_PER_ITEM)) begin
                        r_state <= S_SKIP0;
                    end else if (r_hold) begin
                        o_last <= 1'b0;
                        o_out_valid <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= i_status.interp ? S_DIVX0 : S_ADV;
                    end
                end
                S_DIVX0: r_state <= S_DIVX;
                S_DIVX: if (i_status.div_done) r_state <= S_DIVY0;
                S_DIVY0: r_state <= S_DIVY;
                S_DIVY: if (i_status.div_done) r_state <= S_ADV;
                S_ADV: begin
                    r_count <= r_count + 1'b1;
                    r_hold <= 1'b1;
                    r_state <= S_CHECK;
                end
                S_EMIT: if (i_out_ready) begin
                    o_out_valid <= 1'b0;
                    r_hold <= 1'b0;
                    r_state <= o_last ? S_FIN : S_CHECK;
                end
                S_SKIP0: r_state <= S_SKIP;
                S_SKIP: if (i_status.skip_done) begin
                    // held point stays held; emit it as last after skip
                    r_state <= S_CHECK;
                end
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/arc_length_uniform_resampler.sv -----
// top level of the arc length uniform resampler
// depends on alur_pkg, alur_ctrl, alur_datapath
`timescale 1ns / 1ps

// One input transaction carries one polyline sample; it emits zero to
// MAX_POINTS_PER_ITEM point transactions. Each interpolated point runs the
// bit-serial 64-bit rounding divider once for x and once for y; a point copied
// from a sample skips the divider. An edge start or empty edge is taken without
// leaving the idle state. A capped item also runs the serial skip divider. One
// item is in work at a time. Each point is held until the consumer takes it.
module arc_length_uniform_resampler
    import alur_pkg::*;
#(
    parameter int MAX_POINTS_PER_ITEM = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);
    // output coordinates keep only the low coordinate bits
    localparam logic [31:0] CoordMask = (COORD_WIDTH < 32)
        ? 32'((64'd1 << COORD_WIDTH) - 64'd1) : 32'hFFFF_FFFF;

    logic [31:0] r_step_length;
    t_cmd cmd;
    t_status status;
    logic [31:0] x, y;
    logic ovf, last;

    // step length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_step_length <= 32'd65536;
        else if (i_cfg_we) r_step_length <= i_cfg_wdata;
    end

    alur_ctrl #(.MAX_POINTS_PER_ITEM(MAX_POINTS_PER_ITEM)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(status), .o_cmd(cmd), .o_last(last)
    );

    alur_datapath #(
        .MAX_POINTS_PER_ITEM(MAX_POINTS_PER_ITEM),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dp (
        .i_clk, .i_cmd(cmd), .i_item(i_in_data), .i_step_length(r_step_length),
        .i_rst_n, .o_status(status), .o_x(x), .o_y(y), .o_ovf(ovf)
    );

    assign o_out_data = '{out_x: x & CoordMask, out_y: y & CoordMask,
                          last_of_run: last, overflowed: ovf};
endmodule

// ----- hw/rtl/alur_checker.sv -----
// port-level checker for the resampler, bound to the top level
// depends on alur_pkg
`timescale 1ns / 1ps

module alur_checker
    import alur_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);
    // no new input while a point waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken while output pending");
    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");
    // after a last point the block returns to accepting input
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last_of_run |=> ##1 o_in_ready)
        else $error("no return to idle after last point");
endmodule

bind arc_length_uniform_resampler alur_checker u_chk (
    .i_clk, .i_rst_n, .o_in_ready, .o_out_valid, .i_out_ready, .o_out_data
);

// ----- bench/arc_length_uniform_resampler_tb.sv -----
// self-checking testbench for the arc length uniform resampler
// depends on alur_pkg and arc_length_uniform_resampler; predicts every point
`timescale 1ns / 1ps

module arc_length_uniform_resampler_tb;
    import alur_pkg::*;

    localparam int MaxPts = 64;
    localparam longint CycleLimit = 64'd10_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    arc_length_uniform_resampler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state, mirrors the block's arc tracking
    logic [31:0]     step_reg;
    logic [63:0]     target_q;
    longint          last_x, last_y;
    logic [63:0]     last_dist;
    logic [63:0]     edge_owed;
    t_out_item       points_due[$];
    int              errors = 0;
    longint          cycles = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    task automatic report(input string what, input t_out_item got, input t_out_item want);
        errors++;
        $display("mismatch %s: got x=%h y=%h l=%b o=%b want x=%h y=%h l=%b o=%b", what,
                 got.out_x, got.out_y, got.last_of_run, got.overflowed,
                 want.out_x, want.out_y, want.last_of_run, want.overflowed);
    endtask

    function automatic longint blend(longint a, longint b, logic [63:0] num, logic [63:0] den);
        longint      d;
        logic [63:0] mag;
        logic [127:0] q;
        d = b - a;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        q = (128'(mag) * 128'(num) + 128'(den >> 1)) / 128'(den);
        return (d < 0) ? a - longint'(q[63:0]) : a + longint'(q[63:0]);
    endfunction

    // work out the points one sample causes and queue them
    task automatic predict_sample(input t_in_item s);
        logic        es;
        logic [63:0] stp, sdist, arc, el;
        longint      px, py, ox, oy;
        int          n, first;
        t_out_item   p;
        es = s.edge_start | s.cycle_start;
        stp = (step_reg == 0) ? 64'd1 : 64'(step_reg);
        px = longint'($signed(s.pos_x));
        py = longint'($signed(s.pos_y));
        arc = 64'(s.arc_pos);
        el = 64'(s.edge_len);
        n = 0;
        first = points_due.size();
        if (s.cycle_start) begin
            target_q = stp >> 1;
            edge_owed = 0;
        end
        if (es) begin
            target_q = (target_q >= edge_owed) ? target_q - edge_owed : 64'd0;
            edge_owed = el;
        end
        if (el == 0) return;
        sdist = s.reversed ? ((arc > el) ? 64'd0 : el - arc) : arc;
        if (es) begin
            last_x = px; last_y = py; last_dist = sdist;
            return;
        end
        while (target_q <= sdist && n < MaxPts) begin
            if (sdist <= last_dist) begin
                ox = px; oy = py;
            end else if (target_q <= last_dist) begin
                ox = last_x; oy = last_y;
            end else begin
                ox = blend(last_x, px, target_q - last_dist, sdist - last_dist);
                oy = blend(last_y, py, target_q - last_dist, sdist - last_dist);
            end
            p.out_x = ox[31:0];
            p.out_y = oy[31:0];
            p.last_of_run = 1'b0;
            p.overflowed = 1'b0;
            points_due.push_back(p);
            target_q += stp;
            n++;
        end
        if (target_q <= sdist) begin
            target_q += ((sdist - target_q) / stp + 1) * stp;
            for (int k = first; k < points_due.size(); k++) points_due[k].overflowed = 1'b1;
        end
        if (n > 0) points_due[points_due.size() - 1].last_of_run = 1'b1;
        last_x = px; last_y = py; last_dist = sdist;
    endtask

    // output side: random stall and compare with the oldest expected point
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (points_due.size() == 0) begin
                report("unexpected", o_out_data, '0);
            end else begin
                if (o_out_data !== points_due[0]) report("point", o_out_data, points_due[0]);
                void'(points_due.pop_front());
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_step(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        step_reg = v;
    endtask

    // one transaction on the input channel, with random idle before it
    task automatic send(input t_in_item s);
        int idle;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct) idle++;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_sample(s);
    endtask

    // let the block drain, then allow for work on items with no result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (points_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(input logic cs, input logic es, input logic rv,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] arc, input logic [31:0] el);
        t_in_item s;
        s.cycle_start = cs; s.edge_start = es; s.reversed = rv;
        s.pos_x = x; s.pos_y = y; s.arc_pos = arc; s.edge_len = el;
        return s;
    endfunction

    // one edge of random shape, mostly short arcs so targets are reached
    task automatic random_edge(input logic cs, input int samples);
        logic [31:0] el, arc, stepv;
        logic        rv;
        t_in_item    s;
        el = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(32'h0008_0000, 1);
        if ($urandom_range(19) == 0) el = $urandom;
        rv = 1'($urandom_range(1));
        arc = 0;
        for (int i = 0; i < samples; i++) begin
            stepv = el / samples + $urandom_range(32'h0000_4000);
            if ($urandom_range(7) == 0) arc = $urandom;
            else if (i > 0) arc = arc + stepv;
            s = mk(cs && i == 0, i == 0, rv, $urandom, $urandom, arc, el);
            if ($urandom_range(9) < 7) begin
                s.pos_x = $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
                s.pos_y = $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            end
            send(s);
        end
    endtask

    // directed stimulus with fixed answers where they are obvious
    typedef struct {
        t_in_item s;
        logic     check;
        t_out_item want;
    } t_row;

    t_row rows[$];

    initial begin : stim
        t_out_item   z;
        t_row        r;
        logic [31:0] cfgs[4];
        i_out_ready <= 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        step_reg = 32'd65536;
        target_q = 64'd32768;
        last_x = 0; last_y = 0; last_dist = 0; edge_owed = 0;

        // directed rows
        z = '0;
        r.check = 0; r.want = z;
        r.s = mk(1, 1, 0, 32'h0, 32'h0, 0, 32'h0004_0000); rows.push_back(r);
        // first target at half step: point at 0.5 on the x line
        r.s = mk(0, 0, 0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0004_0000);
        r.check = 1; r.want = '{32'h0000_8000, 32'h0, 1'b1, 1'b0}; rows.push_back(r);
        r.check = 0;
        r.s = mk(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0004_0000, 32'h0004_0000);
        rows.push_back(r);
        r.s = mk(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000, 32'h0004_0000);
        rows.push_back(r);                              // distance going back
        r.s = mk(0, 1, 1, 32'h1234_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0003_0000);
        rows.push_back(r);                              // reversed arc beyond edge
        r.s = mk(0, 0, 1, 32'h0, 32'h0, 32'h0, 32'h0003_0000); rows.push_back(r);
        r.s = mk(0, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0); rows.push_back(r);   // empty edge
        r.s = mk(0, 0, 0, 32'h0, 32'h0, 32'h5, 32'h0); rows.push_back(r);
        r.s = mk(0, 1, 0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF); rows.push_back(r);
        r.s = mk(0, 0, 0, 32'h0100_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        rows.push_back(r);                              // capped item
        r.s = mk(1, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0001_0000); rows.push_back(r);
        r.s = mk(0, 0, 0, 32'h0, 32'h0, 32'h0000_8000, 32'h0001_0000); rows.push_back(r);
        foreach (rows[i]) begin
            if (rows[i].check) begin
                send(rows[i].s);
                if (points_due.size() == 0 || points_due[points_due.size()-1] !== rows[i].want)
                    report("directed", points_due[points_due.size()-1], rows[i].want);
            end else begin
                send(rows[i].s);
            end
        end
        drain();

        // random phases through several step settings and idle mixes
        cfgs = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0000_6000};
        for (int ph = 0; ph < 4; ph++) begin
            write_step(ph == 3 ? $urandom_range(32'h0002_0000, 32'h0000_2000) : cfgs[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (ph == 0) write_step(32'h0000_4000 + $urandom_range(32'h8000));
            if (ph == 2) write_step(32'h0000_8000);
            for (int e = 0; e < 6; e++) begin
                random_edge(e == 0 || $urandom_range(5) == 0, $urandom_range(8, 2));
                if ($urandom_range(9) == 0)
                    send(mk(1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                            $urandom, $urandom));
            end
            drain();
        end

        if (points_due.size() != 0) report("missing", '0, points_due[0]);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
